// ----- hdl/swd_pkg.sv -----
// ----------------------------------------------------------------------------
// swd_pkg
// Shared constants and types for the sequence window duplicate filter.
// ----------------------------------------------------------------------------
package swd_pkg;

	localparam int SWD_WINDOW_BITS = 256;
	localparam int SWD_ID_BITS     = 16;

	// per-item command codes
	localparam logic CMD_CHECK  = 1'b0;
	localparam logic CMD_RECORD = 1'b1;

	// control from the beat stage into the window state
	typedef struct packed {
		logic fire;
		logic cmd;
	} swd_ctl_t;

endpackage

// ----- hdl/swd_window.sv -----
// ----------------------------------------------------------------------------
// swd_window
// Seen-window state, newest id and started flag, with the duplicate check
// and the registered window update for one beat.
// ----------------------------------------------------------------------------
module swd_window #(
	parameter int WINDOW_BITS = swd_pkg::SWD_WINDOW_BITS,
	parameter int ID_BITS     = swd_pkg::SWD_ID_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  swd_pkg::swd_ctl_t  ctl,
	input  logic [ID_BITS-1:0] id,
	output logic               dup
);
	import swd_pkg::*;

	localparam int IDX_W = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;
	localparam int DW    = ID_BITS + IDX_W + 1;
	localparam logic [ID_BITS-1:0] HALF = {1'b1, {(ID_BITS-1){1'b0}}};
	localparam logic [DW-1:0] WIN_EXT = DW'(WINDOW_BITS);

	logic [WINDOW_BITS-1:0] seen_q, seen_next;
	logic [ID_BITS-1:0]     newest_q, newest_next;
	logic                   started_q, started_next;

	logic [ID_BITS-1:0] back, fwd;
	logic [DW-1:0]      back_ext, fwd_ext;
	logic [IDX_W-1:0]   back_idx;
	logic               in_win, is_newer, record;

	assign back     = newest_q - id;
	assign fwd      = id - newest_q;
	assign back_ext = DW'(back);
	assign fwd_ext  = DW'(fwd);
	assign back_idx = back_ext[IDX_W-1:0];
	assign in_win   = back_ext < WIN_EXT;
	assign is_newer = back > HALF;
	assign record   = ctl.fire && (ctl.cmd == CMD_RECORD);

	// judged against the state before this beat records anything
	assign dup = started_q && in_win && seen_q[back_idx];

	always_comb begin
		seen_next    = seen_q;
		newest_next  = newest_q;
		started_next = started_q;
		if (record) begin
			if (!started_q) begin
				newest_next  = id;
				seen_next[0] = 1'b1;
				started_next = 1'b1;
			end else if (is_newer) begin
				// slide up by the forward distance, flush when it spans the window
				if (fwd_ext >= WIN_EXT) begin
					seen_next = '0;
				end else begin
					seen_next = seen_q << fwd;
				end
				seen_next[0] = 1'b1;
				newest_next  = id;
			end else if (in_win) begin
				seen_next[back_idx] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= '0;
			newest_q  <= '0;
			started_q <= 1'b0;
		end else begin
			seen_q    <= seen_next;
			newest_q  <= newest_next;
			started_q <= started_next;
		end
	end

	a_record_starts: assert property (@(posedge clk) disable iff (!arst_n)
		record |=> started_q)
		else $error("record did not set started");

	a_dup_needs_start: assert property (@(posedge clk) disable iff (!arst_n)
		dup |-> started_q)
		else $error("duplicate flagged before any record");

	a_anchor: assert property (@(posedge clk) disable iff (!arst_n)
		(record && !started_q) |=> (newest_q == $past(id)) && seen_q[0])
		else $error("first record did not anchor the window");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!record |=> $stable(newest_q) && $stable(seen_q) && $stable(started_q))
		else $error("window state changed without a record");

	a_newest_seen: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> seen_q[0])
		else $error("newest id not marked seen");

endmodule

// ----- hdl/sequence_window_dedup_core.sv -----
// ----------------------------------------------------------------------------
// sequence_window_dedup_core
// Duplicate filter for wrapping packet sequence numbers with a sliding window.
// ----------------------------------------------------------------------------
// Takes one beat per clock and returns one duplicate flag per beat through
// the input register, then the result register. The rate is set
// by the window update: check, barrel shift and bit set close
// from the input register into the window state, so back-to-back beats see
// the state left by the one before. A stalled result holds the input stage;
// a new beat is still taken whenever the input register is empty or moving.
module sequence_window_dedup_core #(
	parameter int WINDOW_BITS = swd_pkg::SWD_WINDOW_BITS,
	parameter int ID_BITS     = swd_pkg::SWD_ID_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               cmd,
	input  logic [ID_BITS-1:0] seq_id,
	output logic               result_valid,
	input  logic               result_stall,
	output logic               duplicate
);
	import swd_pkg::*;

	logic               valid_s1;
	logic               cmd_s1;
	logic [ID_BITS-1:0] id_s1;
	logic               result_valid_q;
	logic               duplicate_q;
	logic               out_free, fire, dup;
	swd_ctl_t           ctl;

	assign out_free   = !result_valid_q || !result_stall;
	assign fire       = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;

	assign ctl.fire = fire;
	assign ctl.cmd  = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			cmd_s1 <= cmd;
			id_s1  <= seq_id;
		end
	end

	swd_window #(
		.WINDOW_BITS (WINDOW_BITS),
		.ID_BITS     (ID_BITS)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.id     (id_s1),
		.dup    (dup)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			duplicate_q <= dup;
		end
	end

	assign result_valid = result_valid_q;
	assign duplicate    = duplicate_q;

endmodule

// ----- sim/sequence_window_dedup_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sequence_window_dedup_core_tb
// Feeds check and record beats of wrapping packet ids into the duplicate
// filter, with phases of sender gaps and result stalls, and compares each
// duplicate flag with a typed value or a behavioral copy of the seen-window.
// ----------------------------------------------------------------------------
module sequence_window_dedup_core_tb;
	import swd_pkg::*;

	localparam int WIN     = SWD_WINDOW_BITS;
	localparam int IDW     = SWD_ID_BITS;
	localparam int WIN_LOG = $clog2(WIN);
	localparam logic [IDW-1:0] ID_HALF = IDW'(1 << (IDW - 1));
	localparam int HANG_LIMIT       = 4000;
	localparam int REPORT_MAX       = 10;
	localparam int RANDOM_PER_PHASE = 470;
	localparam int DIRECTED_ROWS    = 24;

	typedef struct packed {
		logic           op;
		logic [IDW-1:0] id;
		logic           typed;
		logic           dup;
	} beat_row_t;

	logic           clk          = 1'b0;
	logic           arst_n       = 1'b0;
	logic           item_valid   = 1'b0;
	logic           cmd          = CMD_CHECK;
	logic [IDW-1:0] seq_id       = '0;
	logic           result_stall = 1'b0;
	logic           item_stall;
	logic           result_valid;
	logic           duplicate;

	// window model: bit d stands for id (win_newest - d)
	logic [WIN-1:0] win_seen    = '0;
	logic [IDW-1:0] win_newest  = '0;
	logic           win_started = 1'b0;

	logic dup_expected_q [$];
	int   idle_pct    = 0;
	int   stall_pct   = 0;
	int   fail_count  = 0;
	int   hang_cycles = 0;

	// expected flag typed only where it is obvious
	beat_row_t directed_rows [DIRECTED_ROWS] = '{
		'{CMD_CHECK,  IDW'(16'h0000), 1'b1, 1'b0},	// nothing recorded yet
		'{CMD_CHECK,  IDW'(16'hFFFF), 1'b1, 1'b0},
		'{CMD_RECORD, IDW'(100),      1'b1, 1'b0},	// first record anchors the window
		'{CMD_CHECK,  IDW'(100),      1'b1, 1'b1},
		'{CMD_RECORD, IDW'(100),      1'b1, 1'b1},	// repeat of the newest id
		'{CMD_RECORD, IDW'(99),       1'b0, 1'b0},
		'{CMD_CHECK,  IDW'(99),       1'b0, 1'b0},
		'{CMD_RECORD, IDW'(32868),    1'b0, 1'b0},	// exactly half the id range away
		'{CMD_CHECK,  IDW'(32868),    1'b0, 1'b0},
		'{CMD_RECORD, IDW'(101),      1'b0, 1'b0},	// newer by one
		'{CMD_CHECK,  IDW'(99),       1'b0, 1'b0},
		'{CMD_RECORD, IDW'(356),      1'b0, 1'b0},	// shift by window size minus one
		'{CMD_CHECK,  IDW'(101),      1'b0, 1'b0},	// oldest bit of the window
		'{CMD_CHECK,  IDW'(100),      1'b0, 1'b0},	// just outside the window
		'{CMD_RECORD, IDW'(612),      1'b0, 1'b0},	// shift by window size clears
		'{CMD_CHECK,  IDW'(356),      1'b0, 1'b0},
		'{CMD_RECORD, IDW'(312),      1'b0, 1'b0},	// old id beyond the window
		'{CMD_CHECK,  IDW'(312),      1'b0, 1'b0},
		'{CMD_RECORD, IDW'(33379),    1'b0, 1'b0},	// largest forward step
		'{CMD_RECORD, IDW'(16'hFFFF), 1'b0, 1'b0},
		'{CMD_RECORD, IDW'(16'h0000), 1'b0, 1'b0},	// wrap of the id space
		'{CMD_CHECK,  IDW'(16'hFFFF), 1'b0, 1'b0},
		'{CMD_CHECK,  IDW'(16'h5555), 1'b0, 1'b0},
		'{CMD_RECORD, IDW'(16'hAAAA), 1'b0, 1'b0}
	};

	sequence_window_dedup_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.cmd          (cmd),
		.seq_id       (seq_id),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.duplicate    (duplicate)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	// checks the id against the window, then records it on a record beat
	function automatic logic filter_step(input logic op, input logic [IDW-1:0] id);
		logic [IDW-1:0] back;
		logic [IDW-1:0] fwd;
		logic           dup;
		back = win_newest - id;
		fwd  = id - win_newest;
		dup  = 1'b0;
		if (win_started && back < WIN)
			dup = win_seen[back[WIN_LOG-1:0]];
		if (op == CMD_RECORD) begin
			if (!win_started) begin
				win_newest  = id;
				win_seen[0] = 1'b1;
				win_started = 1'b1;
			end else if (back > ID_HALF) begin
				if (fwd >= WIN)
					win_seen = '0;
				else
					win_seen = win_seen << fwd;
				win_newest  = id;
				win_seen[0] = 1'b1;
			end else if (back < WIN) begin
				win_seen[back[WIN_LOG-1:0]] = 1'b1;
			end
		end
		return dup;
	endfunction

	task automatic push_beat(input logic op, input logic [IDW-1:0] id, input logic typed,
			input logic typed_dup);
		logic model_dup;
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		cmd        <= op;
		seq_id     <= id;
		do
			@(posedge clk);
		while (item_stall !== 1'b0);
		model_dup = filter_step(op, id);
		dup_expected_q.push_back(typed ? typed_dup : model_dup);
	endtask

	task automatic wait_results_drained();
		item_valid <= 1'b0;
		while (dup_expected_q.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin : result_check
		logic want;
		if (result_valid === 1'b1 && result_stall === 1'b0) begin
			if (dup_expected_q.size() == 0) begin
				if (fail_count < REPORT_MAX)
					$display("result beat with nothing expected: duplicate=%b", duplicate);
				fail_count++;
			end else begin
				want = dup_expected_q.pop_front();
				if (duplicate !== want) begin
					if (fail_count < REPORT_MAX)
						$display("duplicate mismatch: expected %b, got %b", want, duplicate);
					fail_count++;
				end
			end
		end
	end

	// ends a run in which neither channel moves for too long
	always @(posedge clk) begin
		if ((item_valid === 1'b1 && item_stall === 1'b0) ||
				(result_valid === 1'b1 && result_stall === 1'b0)) begin
			hang_cycles <= 0;
		end else if (hang_cycles >= HANG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			hang_cycles <= hang_cycles + 1;
		end
	end

	initial begin
		logic           op;
		logic [IDW-1:0] id;
		int             pick;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			push_beat(directed_rows[i].op, directed_rows[i].id, directed_rows[i].typed,
				directed_rows[i].dup);
		wait_results_drained();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 60; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 60; end
				default: begin idle_pct = 12; stall_pct = 12; end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				pick = $urandom_range(99);
				// mostly ids around the newest, some far jumps and noise
				if (pick < 50)
					id = win_newest - IDW'($urandom_range(300));
				else if (pick < 75)
					id = win_newest + IDW'($urandom_range(40, 1));
				else if (pick < 85)
					id = win_newest + IDW'($urandom_range(300, 200));
				else if (pick < 90)
					id = win_newest + ID_HALF - 1'b1 + IDW'($urandom_range(2));
				else
					id = IDW'($urandom);
				op = ($urandom_range(99) < 65) ? CMD_RECORD : CMD_CHECK;
				push_beat(op, id, 1'b0, 1'b0);
			end
			// sender holds off until every flag is back
			wait_results_drained();
		end

		repeat (8) @(posedge clk);
		if (fail_count == 0 && dup_expected_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
